/* design/pcdp_pkg.sv */
// Package for the position compensated double-pulse timer.
// Holds the item codes, timing reset values, shared types and the saturation helper.
// Used by every module of the block; depends on nothing.
`default_nettype none

package pcdp_pkg;

    // Counter limit reached when the hammer has been idle long enough.
    localparam logic [13:0] TIMER_LIMIT = 14'd10000;

    // Timing values after reset, in milliseconds.
    localparam logic [15:0] FIRST_LEN_RESET    = 16'd20;
    localparam logic [15:0] SECOND_START_RESET = 16'd70;
    localparam logic [15:0] SECOND_LEN_RESET   = 16'd10;

    // Item kinds.
    typedef enum logic [1:0] {
        KIND_TICK      = 2'd0,
        KIND_CORR_BEAT = 2'd1,
        KIND_RAW_BEAT  = 2'd2,
        KIND_SET_VALUE = 2'd3
    } kind_t;

    // Timing value selector of a set item.
    typedef enum logic [1:0] {
        SEL_FIRST_LEN    = 2'd0,
        SEL_SECOND_START = 2'd1,
        SEL_SECOND_LEN   = 2'd2,
        SEL_NONE         = 2'd3
    } param_sel_t;

    // One input request as held in the input register.
    typedef struct packed {
        kind_t             kind;
        logic signed [31:0] arm_position;
        param_sel_t        param_index;
        logic [15:0]       param_value;
    } item_t;

    // The three pulse timing values.
    typedef struct packed {
        logic [15:0] first_len;
        logic [15:0] second_start;
        logic [15:0] second_len;
    } timing_t;

    // Clamp a non-negative 25-bit value to 16 bits.
    function automatic logic [15:0] sat16(input logic [24:0] v);
        logic [15:0] r;
        if (v > 25'd65535)
        begin
            r = 16'hFFFF;
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* design/pcdp_in_stage.sv */
// Input register of the double-pulse timer: holds one accepted request.
// Depends on pcdp_pkg for the item type.
`default_nettype none

module pcdp_in_stage
    import pcdp_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         kind,
    input  wire logic signed [31:0] arm_position,
    input  wire logic [1:0]         param_index,
    input  wire logic [15:0]        param_value,
    input  wire logic               advance,
    output logic                    item_valid,
    output item_t                   item
);

    logic  item_valid_reg;
    logic  item_valid_next;
    item_t item_reg;

    // A new request may enter when the register is empty or is being consumed.
    assign in_ready = !item_valid_reg || advance;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (in_ready)
        begin
            item_valid_next = in_valid;
        end
    end

    // Valid flag under reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
        end
    end

    // Payload capture, no reset needed.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg.kind         <= kind_t'(kind);
            item_reg.arm_position <= arm_position;
            item_reg.param_index  <= param_sel_t'(param_index);
            item_reg.param_value  <= param_value;
        end
    end

    assign item_valid = item_valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

/* design/pcdp_comp.sv */
// Arm position compensation: derives the pulse timing from the arm position.
// Piecewise-linear in the position; depends on pcdp_pkg for types and sat16.
`default_nettype none

module pcdp_comp
    import pcdp_pkg::*;
(
    input  wire logic signed [31:0] arm_position,
    output timing_t                 timing
);

    localparam logic signed [33:0] POS_5000 = 34'sd5000;
    localparam logic signed [33:0] POS_7000 = 34'sd7000;
    localparam logic signed [33:0] POS_9000 = 34'sd9000;

    logic signed [33:0] pos;
    logic signed [33:0] d_lo;
    logic signed [33:0] d_mid;
    logic signed [33:0] d_hi;
    logic [33:0]        m_mid;
    logic [33:0]        m_hi;
    logic [23:0]        q_lo;
    logic [23:0]        q_mid;
    logic [23:0]        q_hi;
    logic [15:0]        fl;

    assign pos = {{2{arm_position[31]}}, arm_position};

    // Distances from the breakpoints; each is only used where it is non-negative.
    assign d_lo  = POS_5000 - pos;
    assign d_mid = POS_7000 - pos;
    assign d_hi  = pos - POS_9000;

    // Slope 2/1024 is a shift by nine; slope 5/1024 is times five then a shift by ten.
    assign q_lo  = d_lo[32:9];
    assign m_mid = {d_mid[31:0], 2'b00} + d_mid[33:0];
    assign m_hi  = {d_hi[31:0], 2'b00} + d_hi[33:0];
    assign q_mid = m_mid[33:10];
    assign q_hi  = m_hi[33:10];

    // First pulse length, and the second length as three quarters of it.
    always_comb
    begin
        if (pos > POS_5000)
        begin
            fl = 16'd16;
        end
        else
        begin
            fl = sat16({1'b0, q_lo} + 25'd16);
        end
        timing.first_len  = fl;
        timing.second_len = fl - {2'b00, fl[15:2]};
    end

    // Start of the second pulse.
    always_comb
    begin
        if (pos > POS_9000)
        begin
            timing.second_start = sat16({1'b0, q_hi} + 25'd40);
        end
        else if (pos < POS_5000)
        begin
            timing.second_start = sat16({1'b0, q_lo} + 25'd50);
        end
        else if (pos < POS_7000)
        begin
            timing.second_start = sat16({1'b0, q_mid} + 25'd40);
        end
        else
        begin
            timing.second_start = 16'd40;
        end
    end

endmodule

`default_nettype wire

/* design/position_compensated_double_pulse_top.sv */
// Top level of the position compensated double-pulse timer.
// Instantiates pcdp_in_stage and pcdp_comp; depends on pcdp_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) carries kind, arm_position,
//   param_index and param_value. A tick advances the millisecond counter,
//   which stops at its limit, and yields one result request; beats and set
//   items update the state and yield nothing.
//   Output channel (out_valid/out_ready) carries hammer_drive and
//   elapsed_ms, the drive level and counter value after that tick.
//   Path: a tick is held in the input register, then in the result
//   register. Throughput: one request per cycle unless a tick waits;
//   the state update is a single combinational pass between the input
//   register and the state registers.
//   When the receiver stalls, the result register holds; beats and set
//   items keep flowing, and a tick waits in the input register, with
//   in_ready low, until the result register is free.
//   Reset: the counter goes to its idle limit, the timing values to
//   20, 70 and 10 ms, and both register stages empty.
`default_nettype none

module position_compensated_double_pulse_top
    import pcdp_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         kind,
    input  wire logic signed [31:0] arm_position,
    input  wire logic [1:0]         param_index,
    input  wire logic [15:0]        param_value,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    hammer_drive,
    output logic [13:0]             elapsed_ms
);

    logic    item_valid;
    item_t   item;
    logic    advance;
    logic    is_tick;
    timing_t comp_timing;

    logic [13:0] elapsed_reg;
    logic [13:0] elapsed_next;
    timing_t     timing_reg;
    timing_t     timing_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        hammer_drive_reg;
    logic        hammer_drive_next;
    logic [13:0] elapsed_ms_reg;

    logic [13:0] tick_elapsed;
    logic [16:0] tick_ext;
    logic [16:0] window_end;

    pcdp_in_stage u_in_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .arm_position (arm_position),
        .param_index  (param_index),
        .param_value  (param_value),
        .advance      (advance),
        .item_valid   (item_valid),
        .item         (item)
    );

    pcdp_comp u_comp (
        .arm_position (item.arm_position),
        .timing       (comp_timing)
    );

    // A tick needs a free result register; other requests always proceed.
    assign is_tick = (item.kind == KIND_TICK);
    assign advance = item_valid && (!is_tick || !out_valid_reg || out_ready);

    // Counter step and drive decision for a tick.
    assign tick_elapsed = (elapsed_reg < TIMER_LIMIT) ? (elapsed_reg + 14'd1) : elapsed_reg;
    assign tick_ext     = {3'b000, tick_elapsed};
    assign window_end   = {1'b0, timing_reg.second_start} + {1'b0, timing_reg.second_len};
    assign hammer_drive_next = (tick_ext < {1'b0, timing_reg.first_len})
        || ((tick_ext > {1'b0, timing_reg.second_start}) && (tick_ext < window_end));

    // State update for the request being consumed.
    always_comb
    begin
        elapsed_next = elapsed_reg;
        timing_next  = timing_reg;
        if (advance)
        begin
            case (item.kind)
                KIND_TICK:
                begin
                    elapsed_next = tick_elapsed;
                end
                KIND_CORR_BEAT:
                begin
                    timing_next  = comp_timing;
                    elapsed_next = 14'd0;
                end
                KIND_RAW_BEAT:
                begin
                    elapsed_next = 14'd0;
                end
                KIND_SET_VALUE:
                begin
                    case (item.param_index)
                        SEL_FIRST_LEN:    timing_next.first_len    = item.param_value;
                        SEL_SECOND_START: timing_next.second_start = item.param_value;
                        SEL_SECOND_LEN:   timing_next.second_len   = item.param_value;
                        default:          timing_next              = timing_reg;
                    endcase
                end
                default:
                begin
                    elapsed_next = elapsed_reg;
                end
            endcase
        end
    end

    // Result register occupancy.
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (advance && is_tick)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Block state and result valid, under reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg             <= TIMER_LIMIT;
            timing_reg.first_len    <= FIRST_LEN_RESET;
            timing_reg.second_start <= SECOND_START_RESET;
            timing_reg.second_len   <= SECOND_LEN_RESET;
            out_valid_reg           <= 1'b0;
        end
        else
        begin
            elapsed_reg   <= elapsed_next;
            timing_reg    <= timing_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (advance && is_tick)
        begin
            hammer_drive_reg <= hammer_drive_next;
            elapsed_ms_reg   <= tick_elapsed;
        end
    end

    assign out_valid    = out_valid_reg;
    assign hammer_drive = hammer_drive_reg;
    assign elapsed_ms   = elapsed_ms_reg;

endmodule

`default_nettype wire
